// ===== hdl/assert_macros.svh =====
// assertion helpers included by the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BDQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define BDQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bdq_pkg.sv =====
package bdq_pkg;

	// storage geometry
	localparam int DEPTH      = 64;
	localparam int ELEM_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// field widths
	localparam int REQ_W  = 3;
	localparam int POS_W  = 16;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 7;

	// bus widths, packed fields rounded up to whole bytes
	localparam int S_BITS = REQ_W + ELEM_WIDTH + POS_W;
	localparam int S_W    = ((S_BITS + 7) / 8) * 8;
	localparam int M_BITS = DATA_W + 1 + STAT_W + OCC_W;
	localparam int M_W    = ((M_BITS + 7) / 8) * 8;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ADD_BACK  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADD_FRONT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_RM_BACK   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RM_FRONT  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CONTAINS  = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

endpackage

// ===== hdl/bounded_deque_with_search.sv =====
// bounded double-ended queue of element words with indexed read and search
//
// s_tdata carries one request transaction: req_type, element, position.
// m_tdata returns exactly one result transaction per request: the read word,
// the search flag, a status code and the occupancy after the request.
// Requests are add back/front, remove back/front, read by index, contains.
//
// Add, remove, read and unused codes go from acceptance to the execute state,
// where the request uses the word a read fetched at acceptance, updates the
// pointers, writes back an added element and loads the result register.
// s_tready then returns, so a request is taken only after the last one is done.
// A contains request walks the ring one entry a cycle through the same read
// port and stops at the first hit or after the last entry held, or on its
// first compare on an empty queue; the execute state then loads the result.
// One request is in work at a time; s_tready is high while the sequencer
// is idle, also while an earlier result still waits in the output register.
// If the receiver stalls, the finished request waits with no side effect
// until the output register is free, and s_tready stays low meanwhile.
// Reset clears head pointer, count and valid flags; memory contents are
// left as they are, since words read from entries without elements go unused.
module bounded_deque_with_search (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// req_type [2:0], element [34:3], position [50:35], zero fill
	input  logic [bdq_pkg::S_W-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// data [31:0], found [32], status [34:33], occupancy [41:35], zero fill
	output logic [bdq_pkg::M_W-1:0] m_tdata
);
	import bdq_pkg::*;

	// sequencer codes
	localparam logic [1:0] SEQ_IDLE = 2'd0;
	localparam logic [1:0] SEQ_SCAN = 2'd1;
	localparam logic [1:0] SEQ_EXEC = 2'd2;

	logic [1:0]            state_q;
	logic [PTR_W-1:0]      head_q;
	logic [CNT_W-1:0]      count_q;
	logic [PTR_W-1:0]      scan_idx_q;
	logic                  found_q;
	logic [REQ_W-1:0]      req_q;
	logic [ELEM_WIDTH-1:0] elem_q;
	logic [POS_W-1:0]      pos_q;

	logic [ELEM_WIDTH-1:0] mem [DEPTH];
	logic [ELEM_WIDTH-1:0] rd_data_q;
	logic                  rd_en;
	logic [PTR_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [PTR_W-1:0]      wr_addr;

	logic [REQ_W-1:0]      in_req;
	logic [ELEM_WIDTH-1:0] in_elem;
	logic [POS_W-1:0]      in_pos;
	logic                  in_fire;
	logic                  out_free;
	logic                  exec_fire;

	logic                  scan_hit;
	logic                  scan_last;
	logic [CNT_W-1:0]      scan_next;

	logic [DATA_W-1:0]     res_data;
	logic [STAT_W-1:0]     res_status;
	logic [CNT_W-1:0]      new_count;
	logic [PTR_W-1:0]      new_head;
	logic                  is_full;
	logic                  is_empty;
	logic                  pos_ok;

	// unpack the request transaction
	assign in_req  = s_tdata[REQ_W-1:0];
	assign in_elem = s_tdata[REQ_W +: ELEM_WIDTH];
	assign in_pos  = s_tdata[REQ_W+ELEM_WIDTH +: POS_W];

	// handshake
	assign s_tready  = (state_q == SEQ_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign exec_fire = (state_q == SEQ_EXEC) && out_free;

	// scan compare on the word read in the previous cycle
	assign scan_next = CNT_W'(scan_idx_q) + CNT_W'(1);
	assign scan_hit  = (CNT_W'(scan_idx_q) < count_q) && (rd_data_q == elem_q);
	assign scan_last = scan_hit || (scan_next >= count_q);

	// memory read address and enable
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		if (in_fire) begin
			rd_en   = (in_req == REQ_READ) || (in_req == REQ_CONTAINS);
			rd_addr = (in_req == REQ_READ) ? head_q + in_pos[PTR_W-1:0] : head_q;
		end else if (state_q == SEQ_SCAN && !scan_last) begin
			rd_en   = 1'b1;
			rd_addr = head_q + scan_next[PTR_W-1:0];
		end
	end

	// flags of the current occupancy
	assign is_full  = (count_q >= CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign pos_ok   = (pos_q < POS_W'(count_q));

	// result and update of the request in work
	always_comb begin
		res_data   = '0;
		res_status = ST_OK;
		new_count  = count_q;
		new_head   = head_q;
		wr_en      = 1'b0;
		wr_addr    = head_q + count_q[PTR_W-1:0];
		unique case (req_q)
			REQ_ADD_BACK: begin
				if (is_full) begin
					res_status = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					new_count = count_q + CNT_W'(1);
				end
			end
			REQ_ADD_FRONT: begin
				if (is_full) begin
					res_status = ST_FULL;
				end else begin
					new_head  = head_q - PTR_W'(1);
					wr_addr   = head_q - PTR_W'(1);
					wr_en     = 1'b1;
					new_count = count_q + CNT_W'(1);
				end
			end
			REQ_RM_BACK: begin
				if (is_empty) begin
					res_status = ST_EMPTY;
				end else begin
					new_count = count_q - CNT_W'(1);
				end
			end
			REQ_RM_FRONT: begin
				if (is_empty) begin
					res_status = ST_EMPTY;
				end else begin
					new_head  = head_q + PTR_W'(1);
					new_count = count_q - CNT_W'(1);
				end
			end
			REQ_READ: begin
				if (pos_ok) begin
					res_data = DATA_W'(rd_data_q);
				end else begin
					res_status = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	// element storage, written only when a request completes
	always_ff @(posedge clk) begin
		if (wr_en && exec_fire) begin
			mem[wr_addr] <= elem_q;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q  <= in_req;
			elem_q <= in_elem;
			pos_q  <= in_pos;
		end
	end

	// sequencer, pointers and scan progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			scan_idx_q <= '0;
			found_q    <= 1'b0;
		end else begin
			unique case (state_q)
				SEQ_IDLE: begin
					if (in_fire) begin
						found_q    <= 1'b0;
						scan_idx_q <= '0;
						state_q    <= (in_req == REQ_CONTAINS) ? SEQ_SCAN : SEQ_EXEC;
					end
				end
				SEQ_SCAN: begin
					if (scan_last) begin
						found_q <= scan_hit;
						state_q <= SEQ_EXEC;
					end else begin
						scan_idx_q <= scan_next[PTR_W-1:0];
					end
				end
				SEQ_EXEC: begin
					if (out_free) begin
						head_q  <= new_head;
						count_q <= new_count;
						state_q <= SEQ_IDLE;
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (exec_fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			m_tdata <= M_W'({OCC_W'(new_count), res_status,
				found_q && (req_q == REQ_CONTAINS), res_data});
		end
	end

	`include "assert_macros.svh"

	// occupancy never exceeds the ring size
	`BDQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "occupancy above depth")
	// memory is written only when a request completes
	`BDQ_ASSERT_IMP(a_write_exec, wr_en && exec_fire, state_q == SEQ_EXEC,
		"memory written outside completion")
	// a completing request hands over to idle
	`BDQ_ASSERT_IMP(a_exec_done, exec_fire, ##1 (state_q == SEQ_IDLE && m_tvalid),
		"completion did not load the output register")
	// occupancy moves only at completion and by at most one
	`BDQ_ASSERT_IMP(a_count_step, count_q != $past(count_q),
		$past(exec_fire) && (count_q == $past(count_q) + CNT_W'(1)
		|| count_q == $past(count_q) - CNT_W'(1)), "unexpected occupancy change")

endmodule

// ===== dv/bdq_checker.sv =====
`timescale 1ns / 100ps

// watches both channels of the deque, predicts each result and compares it
module bdq_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	// req_type [2:0], element [34:3], position [50:35], zero fill
	input  logic [bdq_pkg::S_W-1:0] s_tdata,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	// data [31:0], found [32], status [34:33], occupancy [41:35], zero fill
	input  logic [bdq_pkg::M_W-1:0] m_tdata,
	output int                      mismatches,
	output int                      awaiting
);
	import bdq_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              found;
		logic [STAT_W-1:0] status;
		logic [OCC_W-1:0]  occupancy;
	} deque_result_t;

	// shadow copy of the ring
	logic [ELEM_WIDTH-1:0] held [DEPTH];
	logic [PTR_W-1:0]      front_ptr;
	logic [CNT_W-1:0]      held_count;

	deque_result_t expected_results [$];

	// ring slot at a given distance from the front
	function automatic logic [PTR_W-1:0] ring_slot(input int offset);
		return PTR_W'((int'(front_ptr) + offset) % DEPTH);
	endfunction

	// apply one request to the shadow ring and work out its result
	task automatic apply_request(input logic [S_W-1:0] word, output deque_result_t res);
		logic [REQ_W-1:0]      req;
		logic [ELEM_WIDTH-1:0] elem;
		logic [POS_W-1:0]      pos;
		req  = word[REQ_W-1:0];
		elem = word[REQ_W +: ELEM_WIDTH];
		pos  = word[REQ_W+ELEM_WIDTH +: POS_W];
		res  = '0;
		case (req)
			REQ_ADD_BACK: begin
				if (held_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					held[ring_slot(int'(held_count))] = elem;
					held_count++;
				end
			end
			REQ_ADD_FRONT: begin
				if (held_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					front_ptr       = ring_slot(DEPTH - 1);
					held[front_ptr] = elem;
					held_count++;
				end
			end
			REQ_RM_BACK: begin
				if (held_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					held_count--;
				end
			end
			REQ_RM_FRONT: begin
				if (held_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					front_ptr = ring_slot(1);
					held_count--;
				end
			end
			REQ_READ: begin
				if (pos >= held_count) begin
					res.status = ST_RANGE;
				end else begin
					res.data = DATA_W'(held[ring_slot(int'(pos))]);
				end
			end
			REQ_CONTAINS: begin
				for (int i = 0; i < int'(held_count); i++) begin
					if (held[ring_slot(i)] == elem) begin
						res.found = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		res.occupancy = OCC_W'(held_count);
	endtask

	// check results against the oldest prediction, then record new requests
	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		deque_result_t got;
		if (!arst_n) begin
			front_ptr  = '0;
			held_count = '0;
			expected_results.delete();
			mismatches = 0;
			awaiting   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.data      = m_tdata[DATA_W-1:0];
				got.found     = m_tdata[DATA_W];
				got.status    = m_tdata[DATA_W+1 +: STAT_W];
				got.occupancy = m_tdata[DATA_W+1+STAT_W +: OCC_W];
				if (expected_results.size() == 0) begin
					$error("result transaction with no request waiting: %h", m_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got.data !== want.data) begin
						$error("data: expected %h, got %h", want.data, got.data);
						mismatches++;
					end
					if (got.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, got.found);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatches++;
					end
					if (got.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d", want.occupancy,
							got.occupancy);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_request(s_tdata, want);
				expected_results.push_back(want);
			end
			awaiting = expected_results.size();
		end
	end

endmodule

// ===== dv/bounded_deque_with_search_tb.sv =====
`timescale 1ns / 100ps

module bounded_deque_with_search_tb;
	import bdq_pkg::*;

	// request codes the block leaves unused
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

	localparam int RANDOM_BLOCKS = 13;
	localparam int BLOCK_ITEMS   = 100;
	localparam int LONG_HOLD     = 300;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

	logic           clk;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	logic [S_W-1:0] s_tdata;
	logic           m_tvalid;
	logic           m_tready;
	logic [M_W-1:0] m_tdata;

	int mismatches;
	int awaiting;

	// shared between the sender and the receiver
	bit steady;
	bit hold_req;

	bounded_deque_with_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bdq_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one request transaction, with a random gap ahead of it unless steady is set
	task automatic send_req(input logic [REQ_W-1:0] req, input logic [31:0] elem,
		input logic [POS_W-1:0] pos);
		logic [S_W-1:0] word;
		word                              = '0;
		word[REQ_W-1:0]                   = req;
		word[REQ_W +: ELEM_WIDTH]         = elem;
		word[REQ_W+ELEM_WIDTH +: POS_W]   = pos;
		if (!steady) begin
			while ($urandom_range(0, 99) < 36) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// element words from a small pool so that searches hit often
	function automatic logic [31:0] pick_elem();
		case ($urandom_range(0, 3))
			0, 1:    return 32'($urandom_range(0, 15));
			2:       return ~32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// mostly positions near the occupancy, a few far out
	function automatic logic [POS_W-1:0] pick_pos();
		int r;
		r = $urandom_range(0, 19);
		if (r < 16) return POS_W'($urandom_range(0, 70));
		if (r < 19) return POS_W'($urandom_range(0, 255));
		return POS_W'($urandom_range(0, 65535));
	endfunction

	// a block of random requests, biased to grow, shrink or hover
	task automatic run_block(input traffic_mode_t mode);
		int               lim [6];
		int               r;
		logic [REQ_W-1:0] req;
		case (mode)
			MODE_FILL:  lim = '{40, 70, 75, 80, 90, 98};
			MODE_DRAIN: lim = '{10, 20, 45, 70, 85, 97};
			default:    lim = '{15, 30, 43, 56, 76, 96};
		endcase
		for (int n = 0; n < BLOCK_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < lim[0]) req = REQ_ADD_BACK;
			else if (r < lim[1]) req = REQ_ADD_FRONT;
			else if (r < lim[2]) req = REQ_RM_BACK;
			else if (r < lim[3]) req = REQ_RM_FRONT;
			else if (r < lim[4]) req = REQ_READ;
			else if (r < lim[5]) req = REQ_CONTAINS;
			else req = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
			send_req(req, pick_elem(), pick_pos());
		end
	endtask

	// receiver: random backpressure plus one long hold
	initial begin
		m_tready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
			end
			m_tready <= steady || ($urandom_range(0, 99) >= 36);
		end
	end

	// reset, stimulus and verdict
	initial begin
		traffic_mode_t mode;
		int            n;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		steady   = 1'b0;
		hold_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty errors, unused codes, both ends, range limits, search
		send_req(REQ_RM_BACK, 32'h0, 16'h0);
		send_req(REQ_RM_FRONT, 32'h0, 16'h0);
		send_req(REQ_READ, 32'h0, 16'h0);
		send_req(REQ_CONTAINS, 32'h0, 16'h0);
		send_req(REQ_SPARE_A, 32'hFFFF_FFFF, 16'hFFFF);
		send_req(REQ_SPARE_B, 32'h0, 16'h0);
		send_req(REQ_ADD_BACK, 32'h0, 16'h0);
		send_req(REQ_ADD_BACK, 32'hFFFF_FFFF, 16'hFFFF);
		send_req(REQ_ADD_FRONT, 32'h8000_0001, 16'h0);
		send_req(REQ_ADD_FRONT, 32'h7FFF_FFFE, 16'h0);
		send_req(REQ_READ, 32'h0, 16'h0);
		send_req(REQ_READ, 32'h0, 16'h3);
		send_req(REQ_READ, 32'h0, 16'h4);
		send_req(REQ_READ, 32'h0, 16'hFFFF);
		send_req(REQ_CONTAINS, 32'hFFFF_FFFF, 16'h0);
		send_req(REQ_CONTAINS, 32'h1234_5678, 16'h0);
		send_req(REQ_CONTAINS, 32'h0, 16'h0);
		send_req(REQ_RM_FRONT, 32'h0, 16'h0);
		send_req(REQ_RM_BACK, 32'h0, 16'h0);
		send_req(REQ_READ, 32'h0, 16'h1);
		send_req(REQ_RM_BACK, 32'h0, 16'h0);
		send_req(REQ_RM_FRONT, 32'h0, 16'h0);
		send_req(REQ_RM_FRONT, 32'h0, 16'h0);

		// random: fill to full, hover, drain to empty, repeat
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			case (b % 6)
				0, 1:    mode = MODE_FILL;
				3, 4:    mode = MODE_DRAIN;
				default: mode = MODE_MIX;
			endcase
			if (b == 1) hold_req = 1'b1;
			steady = (b == 8) || (b == 9);
			run_block(mode);
			// let the block drain completely once
			if (b == 6) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (awaiting != 0) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
		steady = 1'b1;

		// drain the outstanding results, then allow a full search to settle
		for (n = 0; n < 100000 && awaiting != 0; n++) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && awaiting == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
